// ----- rtl/slc_pkg.sv -----
// Shared types and constants for the source line classifier.
// Holds the per-line scan state struct, byte codes and line class codes.
// No dependencies.
package slc_pkg;

    // Byte codes that the scanner reacts to.
    localparam logic [7:0] BYTE_NEWLINE = 8'd10;
    localparam logic [7:0] BYTE_TAB     = 8'd9;
    localparam logic [7:0] BYTE_CR      = 8'd13;
    localparam logic [7:0] BYTE_SPACE   = 8'd32;
    localparam logic [7:0] BYTE_HASH    = 8'd35;
    localparam logic [7:0] BYTE_STAR    = 8'd42;
    localparam logic [7:0] BYTE_SLASH   = 8'd47;

    // Line class codes.
    localparam logic [2:0] CLS_BLANK   = 3'd0;
    localparam logic [2:0] CLS_CODE    = 3'd1;
    localparam logic [2:0] CLS_LINE    = 3'd2;
    localparam logic [2:0] CLS_BLOCK   = 3'd3;
    localparam logic [2:0] CLS_PREPROC = 3'd4;

    // Configuration register map (word index) and reset value.
    localparam logic       REG_MAX_LEN   = 1'b0;
    localparam logic [15:0] MAX_LEN_RESET = 16'd80;

    // Flags collected while one line is scanned.
    typedef struct packed {
        logic       seen_nonblank;
        logic       nonblank_before_prev;
        logic [2:0] lead_slash;
        logic       lead_is_hash;
        logic [7:0] prev_byte;
        logic       prev_opener_star;
        logic       opener_found;
        logic       code_before_opener;
        logic       closer_after_opener;
        logic       code_after_closer;
        logic       closer_anywhere;
    } t_line_state;

endpackage

// ----- rtl/slc_byte_scan.sv -----
// Per-byte update of the line scan flags (comment openers, closers, lead bytes).
// Depends on slc_pkg.
module slc_byte_scan import slc_pkg::*; (
    input  logic [7:0]  i_byte,
    input  t_line_state i_state,
    output t_line_state o_state
);

    logic nb;
    logic star_next;

    always_comb begin
        nb        = !(i_byte == BYTE_SPACE || i_byte == BYTE_TAB || i_byte == BYTE_CR);
        star_next = 1'b0;
        o_state   = i_state;

        // First non-blank byte, and the byte right after a leading slash.
        if (!i_state.seen_nonblank) begin
            if (nb) begin
                o_state.lead_is_hash = (i_byte == BYTE_HASH);
                o_state.lead_slash   = (i_byte == BYTE_SLASH) ? 3'b001 : 3'b000;
            end
        end else if (i_state.lead_slash[1:0] == 2'b01) begin
            o_state.lead_slash = i_state.lead_slash | 3'b010 |
                                 {(i_byte == BYTE_SLASH), 2'b00};
        end

        // First opener of the line, then a closer that does not reuse its star.
        if (i_state.opener_found) begin
            if (!i_state.closer_after_opener) begin
                if (!i_state.prev_opener_star && i_state.prev_byte == BYTE_STAR &&
                    i_byte == BYTE_SLASH) begin
                    o_state.closer_after_opener = 1'b1;
                end
            end else if (nb) begin
                o_state.code_after_closer = 1'b1;
            end
        end else if (i_state.prev_byte == BYTE_SLASH && i_byte == BYTE_STAR) begin
            o_state.opener_found       = 1'b1;
            o_state.code_before_opener = i_state.nonblank_before_prev;
            star_next                  = 1'b1;
        end

        // Any closer in the line ends a comment carried in from earlier lines.
        if (i_state.prev_byte == BYTE_STAR && i_byte == BYTE_SLASH) begin
            o_state.closer_anywhere = 1'b1;
        end

        o_state.nonblank_before_prev = i_state.seen_nonblank;
        o_state.seen_nonblank        = i_state.seen_nonblank | nb;
        o_state.prev_byte            = i_byte;
        o_state.prev_opener_star     = star_next;
    end

endmodule

// ----- rtl/slc_line_close.sv -----
// Line classification at the end of a line and the carried block comment flag.
// Depends on slc_pkg.
module slc_line_close import slc_pkg::*; (
    input  t_line_state i_state,
    input  logic        i_in_block,
    output logic [2:0]  o_class,
    output logic        o_in_block
);

    // Priority: blank, open comment, line comment, preprocessor, opener rules.
    always_comb begin
        o_class    = CLS_CODE;
        o_in_block = i_in_block;
        if (!i_state.seen_nonblank) begin
            o_class = CLS_BLANK;
        end else if (i_in_block) begin
            o_class = CLS_BLOCK;
            if (i_state.closer_anywhere) begin
                o_in_block = 1'b0;
            end
        end else if (i_state.lead_slash == 3'b111) begin
            o_class = CLS_LINE;
        end else if (i_state.lead_is_hash) begin
            o_class = CLS_PREPROC;
        end else if (i_state.opener_found) begin
            if (i_state.closer_after_opener) begin
                o_class = (!i_state.code_before_opener && !i_state.code_after_closer) ?
                          CLS_BLOCK : CLS_CODE;
            end else begin
                o_in_block = 1'b1;
                o_class    = i_state.code_before_opener ? CLS_CODE : CLS_BLOCK;
            end
        end
    end

endmodule

// ----- rtl/source_line_classifier.sv -----
// Source line classifier: one text byte per cycle in, one result per line out.
// The last byte of a line is taken into the input register; its result is then written to the result register.
// Throughput: one byte per cycle; a line end waits in the input register only while
// the previous result is still held in the result register by the receiver.
// Reset (synchronous, active low) clears all line state, the line counter and the
// block comment flag, empties both registers, and sets max_line_length to 80.
module source_line_classifier import slc_pkg::*; #(
    parameter int LENGTH_BITS = 16,
    parameter int LINE_BITS   = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Byte input channel
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_text_byte,
    input  logic                   i_end_of_text,
    // Result channel
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [2:0]             o_line_class,
    output logic                   o_line_is_long,
    output logic [LINE_BITS-1:0]   o_line_number,
    output logic [LENGTH_BITS-1:0] o_line_length,
    // Configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int CMP_BITS = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};

    logic [15:0]            r_max_len;
    logic                   r_in_valid;
    logic [7:0]             r_byte;
    logic                   r_last;
    t_line_state            r_line;
    t_line_state            n_line;
    logic [LENGTH_BITS-1:0] r_length;
    logic [LENGTH_BITS-1:0] n_length;
    logic                   r_len_ovf;
    logic                   n_len_ovf;
    logic [LINE_BITS-1:0]   r_lines_done;
    logic                   r_in_block;
    logic                   r_out_valid;
    logic [2:0]             r_class;
    logic                   r_is_long;
    logic [LINE_BITS-1:0]   r_number;
    logic [LENGTH_BITS-1:0] r_out_len;

    t_line_state            scan_state;
    logic                   is_newline;
    logic                   produce;
    logic                   consume;
    logic                   cfg_write;
    logic [2:0]             close_class;
    logic                   close_in_block;
    logic                   is_long;
    logic [LINE_BITS-1:0]   line_num;

    // Configuration register and read data.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_MAX_LEN) ? {16'd0, r_max_len} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (cfg_write && paddr[2] == REG_MAX_LEN) begin
            r_max_len <= pwdata[15:0];
        end
    end

    // Handshake: the input register drains unless its result has nowhere to go.
    assign is_newline = (r_byte == BYTE_NEWLINE);
    assign produce    = is_newline || r_last;
    assign consume    = r_in_valid && (!produce || !r_out_valid || i_ready);
    assign o_ready    = !r_in_valid || consume;
    assign o_valid    = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_text_byte;
            r_last <= i_end_of_text;
        end
    end

    // Byte scan; a newline leaves the line flags as they are.
    slc_byte_scan u_scan (
        .i_byte  (r_byte),
        .i_state (r_line),
        .o_state (scan_state)
    );

    always_comb begin
        n_line    = r_line;
        n_length  = r_length;
        n_len_ovf = r_len_ovf;
        if (!is_newline) begin
            n_line = scan_state;
            if (r_length == LEN_MAX) begin
                n_len_ovf = 1'b1;
            end else begin
                n_length = r_length + LENGTH_BITS'(1);
            end
        end
    end

    // Line end: class, long flag and saturating line number.
    slc_line_close u_close (
        .i_state    (n_line),
        .i_in_block (r_in_block),
        .o_class    (close_class),
        .o_in_block (close_in_block)
    );

    assign is_long  = n_len_ovf ||
                      (CMP_BITS'(n_length) > CMP_BITS'(r_max_len));
    assign line_num = (r_lines_done == LINE_MAX) ? LINE_MAX : r_lines_done + LINE_BITS'(1);

    // Line state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line       <= '0;
            r_length     <= '0;
            r_len_ovf    <= 1'b0;
            r_lines_done <= '0;
            r_in_block   <= 1'b0;
        end else if (consume) begin
            if (produce) begin
                r_line       <= '0;
                r_length     <= '0;
                r_len_ovf    <= 1'b0;
                r_lines_done <= r_last ? '0 : line_num;
                r_in_block   <= r_last ? 1'b0 : close_in_block;
            end else begin
                r_line    <= n_line;
                r_length  <= n_length;
                r_len_ovf <= n_len_ovf;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && produce) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && produce) begin
            r_class   <= close_class;
            r_is_long <= is_long;
            r_number  <= line_num;
            r_out_len <= n_length;
        end
    end

    assign o_line_class   = r_class;
    assign o_line_is_long = r_is_long;
    assign o_line_number  = r_number;
    assign o_line_length  = r_out_len;

    // End of text restarts the line count outside any comment.
    a_text_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && r_last |=> r_lines_done == '0 && !r_in_block)
        else $error("state not restarted after end of text");

    // The sticky overflow bit is only set once the length has saturated.
    a_len_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len_ovf |-> r_length == LEN_MAX)
        else $error("length overflow without saturated length");

    // Lead and opener flags only exist on a line with a non-blank byte.
    a_flags_need_nonblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_line.seen_nonblank |-> !r_line.opener_found && r_line.lead_slash == 3'b000)
        else $error("line flags set on a blank line");

    // A pending result that the receiver has not yet taken must not be overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready |=> r_out_valid && $stable(r_number))
        else $error("pending result lost");

endmodule
